// ===== rtl/fixed_frame_deframer_xor_check_macros.svh =====
// Assertion macros shared by the deframer RTL.
// Included by the modules that check their own logic; needs a port named clock and reset.
`ifndef FIXED_FRAME_DEFRAMER_XOR_CHECK_MACROS_SVH
`define FIXED_FRAME_DEFRAMER_XOR_CHECK_MACROS_SVH

// cond must never be true outside reset
`define FFDX_ASSERT_NEVER(name, cond, msg) \
   name: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

// ante implies cons in the same cycle
`define FFDX_ASSERT_IMPLY(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// ante implies cons in the next cycle
`define FFDX_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/ffdx_pkg.sv =====
// Shared types and constants for the fixed frame deframer.
// No dependencies.
`timescale 1ns / 1ps

package ffdx_pkg;

   localparam int FRAME_LEN_DEF = 16;

   // frame status codes as seen on the result channel
   typedef enum logic [1:0] {
      ST_GOOD      = 2'd0,
      ST_BAD_END   = 2'd1,
      ST_BAD_CHECK = 2'd2
   } status_type;

   // register indexes (byte address / 4)
   typedef enum logic [1:0] {
      REG_START_MARKER = 2'd0,
      REG_END_MARKER   = 2'd1,
      REG_CHECK_SEED   = 2'd2,
      REG_UNUSED       = 2'd3
   } reg_index_type;

   localparam logic [7:0] START_MARKER_RST = 8'hA0;
   localparam logic [7:0] END_MARKER_RST   = 8'hA1;
   localparam logic [7:0] CHECK_SEED_RST   = 8'hFF;

   // framer -> body buffer events
   typedef struct packed {
      logic       wr_en;      // store one body byte
      logic       good;       // frame passed both checks, start drain
      logic       bad;        // frame failed, emit one status word
      status_type status;     // which failure
   } frame_evt_type;

   // body buffer -> framer status
   typedef struct packed {
      logic drain_busy;       // a body run is still being read out
      logic slot_free;        // output path can take one more word next cycle
   } buf_stat_type;

   // one result word
   typedef struct packed {
      status_type status;
      logic [7:0] body_byte;
      logic [3:0] body_index;
      logic       last;
   } rsp_word_type;

endpackage

// ===== rtl/ffdx_body_buf.sv =====
// Body byte store (two banks), drain sequencer and two-word output queue.
// Depends on ffdx_pkg and fixed_frame_deframer_xor_check_macros.svh.
`timescale 1ns / 1ps
`include "fixed_frame_deframer_xor_check_macros.svh"

module ffdx_body_buf
   import ffdx_pkg::*;
#(
   parameter int BODY_LEN = FRAME_LEN_DEF - 3,
   parameter int IDXW     = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  frame_evt_type       evt,
   input  logic [IDXW-1:0]     wr_idx,
   input  logic [7:0]          wr_data,
   output buf_stat_type        stat,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output rsp_word_type        rsp_word
);

   localparam int DEPTH = 2 * (2 ** IDXW);

   logic [7:0]      mem [DEPTH];
   logic [7:0]      mem_rd_ff;

   logic            wr_bank_ff, wr_bank_in;
   logic            drain_bank_ff, drain_bank_in;
   logic            drain_active_ff, drain_active_in;
   logic [IDXW-1:0] drain_idx_ff, drain_idx_in;

   logic            s1_valid_ff, s1_valid_in;
   status_type      s1_status_ff, s1_status_in;
   logic [3:0]      s1_idx_ff, s1_idx_in;
   logic            s1_last_ff, s1_last_in;

   rsp_word_type    q_ff [2];
   logic            q_wptr_ff, q_rptr_ff;
   logic [1:0]      q_cnt_ff, q_cnt_in;

   logic            pop, issue, issue_last;
   logic [2:0]      occ;
   rsp_word_type    push_word;

   assign pop        = rsp_tvalid && rsp_tready;
   assign occ        = {1'b0, q_cnt_ff} + {2'b00, s1_valid_ff};
   assign stat.slot_free  = (occ < 3'd2) || ((occ == 3'd2) && pop);
   assign stat.drain_busy = drain_active_ff;

   assign issue      = drain_active_ff && stat.slot_free;
   assign issue_last = (drain_idx_ff == IDXW'(BODY_LEN - 1));

   always_comb begin
      wr_bank_in      = wr_bank_ff;
      drain_bank_in   = drain_bank_ff;
      drain_active_in = drain_active_ff;
      drain_idx_in    = drain_idx_ff;
      s1_valid_in     = 1'b0;
      s1_status_in    = ST_GOOD;
      s1_idx_in       = 4'd0;
      s1_last_in      = 1'b1;
      if (issue) begin
         s1_valid_in = 1'b1;
         s1_idx_in   = 4'(drain_idx_ff);
         s1_last_in  = issue_last;
         if (issue_last) begin
            drain_active_in = 1'b0;
         end else begin
            drain_idx_in = drain_idx_ff + 1'b1;
         end
      end else if (evt.bad) begin
         s1_valid_in  = 1'b1;
         s1_status_in = evt.status;
      end
      // the next frame fills the other bank while this one drains
      if (evt.good) begin
         drain_active_in = 1'b1;
         drain_idx_in    = '0;
         drain_bank_in   = wr_bank_ff;
         wr_bank_in      = ~wr_bank_ff;
      end
   end

   always_comb begin
      push_word.status     = s1_status_ff;
      push_word.body_byte  = (s1_status_ff == ST_GOOD) ? mem_rd_ff : 8'd0;
      push_word.body_index = s1_idx_ff;
      push_word.last       = s1_last_ff;
      q_cnt_in = q_cnt_ff + {1'b0, s1_valid_ff} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (evt.wr_en) begin
         mem[{wr_bank_ff, wr_idx}] <= wr_data;
      end
      if (issue) begin
         mem_rd_ff <= mem[{drain_bank_ff, drain_idx_ff}];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_bank_ff      <= 1'b0;
         drain_bank_ff   <= 1'b0;
         drain_active_ff <= 1'b0;
         drain_idx_ff    <= '0;
         s1_valid_ff     <= 1'b0;
         q_wptr_ff       <= 1'b0;
         q_rptr_ff       <= 1'b0;
         q_cnt_ff        <= 2'd0;
      end else begin
         wr_bank_ff      <= wr_bank_in;
         drain_bank_ff   <= drain_bank_in;
         drain_active_ff <= drain_active_in;
         drain_idx_ff    <= drain_idx_in;
         s1_valid_ff     <= s1_valid_in;
         q_cnt_ff        <= q_cnt_in;
         if (s1_valid_ff) begin
            q_wptr_ff <= ~q_wptr_ff;
         end
         if (pop) begin
            q_rptr_ff <= ~q_rptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_status_ff <= s1_status_in;
      s1_idx_ff    <= s1_idx_in;
      s1_last_ff   <= s1_last_in;
      if (s1_valid_ff) begin
         q_ff[q_wptr_ff] <= push_word;
      end
   end

   assign rsp_tvalid = (q_cnt_ff != 2'd0);
   assign rsp_word   = q_ff[q_rptr_ff];

   `FFDX_ASSERT_NEVER(a_queue_overflow, occ > 3'd2, "output queue overrun")
   `FFDX_ASSERT_NEVER(a_good_while_drain, evt.good && drain_active_ff,
      "new run started while previous run drains")
   `FFDX_ASSERT_NEXT(a_drain_ends, issue && issue_last, !drain_active_ff || evt.good,
      "drain did not stop after last read")
   `FFDX_ASSERT_IMPLY(a_status_is_last, rsp_tvalid && rsp_word.status != ST_GOOD,
      rsp_word.last, "status word not marked last")

endmodule

// ===== rtl/fixed_frame_deframer_xor_check.sv =====
// Top level of the fixed frame deframer: register port, frame tracking, check byte.
// Depends on ffdx_pkg, ffdx_body_buf and fixed_frame_deframer_xor_check_macros.svh.
`timescale 1ns / 1ps
`include "fixed_frame_deframer_xor_check_macros.svh"

// Usage
//   req_* : one received byte per word. The block hunts for the start marker, tracks
//           a FRAME_LEN byte frame, XORs the body into the check and compares the
//           check byte on arrival and the end marker at the last byte.
//   rsp_* : a good frame gives FRAME_LEN-3 body words, tlast on the final one; a bad
//           frame gives a single status word in tuser with tlast set.
//   csr_* : start marker, end marker and check seed at byte addresses 0, 4 and 8.
// Throughput: one byte per cycle. A body run leaves at one word per cycle while the
//   receiver takes words. A status word passes the s1 register and then the output
//   queue; a body word is first read from the store into a register. Body bytes go
//   into one bank of a two-bank store while the other bank is read out, so the next
//   frame streams in during readout. The final byte of a frame waits only while the
//   previous run is still being read out or the output queue is full.
// Reset: markers and seed return to their defaults and the block starts hunting. No
//   memory clearing pass is needed; accepts input the cycle after reset.
// Receiver stall: results sit in a two-word queue; input keeps flowing until a
//   final byte arrives that would need output space.

module fixed_frame_deframer_xor_check
   import ffdx_pkg::*;
#(
   parameter int FRAME_LEN = FRAME_LEN_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // byte in
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   // results out
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] body_byte, [11:8] body_index, [15:12] zero
   output logic [1:0]  rsp_tuser,   // [1:0] frame_status
   output logic        rsp_tlast,   // last_of_run
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int BODY_LEN  = FRAME_LEN - 3;
   localparam int CHECK_POS = FRAME_LEN - 2;
   localparam int END_POS   = FRAME_LEN - 1;
   localparam int PW        = $clog2(FRAME_LEN);
   localparam int IDXW      = (BODY_LEN > 1) ? $clog2(BODY_LEN) : 1;

   logic [7:0]    start_marker_ff, end_marker_ff, check_seed_ff;
   logic [PW-1:0] pos_ff, pos_in;
   logic [7:0]    chk_ff, chk_in;
   logic          matched_ff, matched_in;

   reg_index_type csr_idx;
   logic          csr_wr, acc, at_end;
   logic [7:0]    rx_byte;
   frame_evt_type evt;
   buf_stat_type  stat;
   rsp_word_type  rsp_word;
   logic [PW-1:0] body_off;

   // ---------------- register port ----------------
   assign csr_pready = 1'b1;
   assign csr_idx    = reg_index_type'(csr_paddr[3:2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      unique case (csr_idx)
         REG_START_MARKER: csr_prdata = {24'd0, start_marker_ff};
         REG_END_MARKER:   csr_prdata = {24'd0, end_marker_ff};
         REG_CHECK_SEED:   csr_prdata = {24'd0, check_seed_ff};
         default:          csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_marker_ff <= START_MARKER_RST;
         end_marker_ff   <= END_MARKER_RST;
         check_seed_ff   <= CHECK_SEED_RST;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_START_MARKER: start_marker_ff <= csr_pwdata[7:0];
            REG_END_MARKER:   end_marker_ff   <= csr_pwdata[7:0];
            REG_CHECK_SEED:   check_seed_ff   <= csr_pwdata[7:0];
            default:          ;
         endcase
      end
   end

   // ---------------- frame tracking ----------------
   assign rx_byte    = req_tdata;
   assign at_end     = (pos_ff == PW'(END_POS));
   assign req_tready = !at_end || (!stat.drain_busy && stat.slot_free);
   assign acc        = req_tvalid && req_tready;
   assign body_off   = pos_ff - 1'b1;

   always_comb begin
      pos_in     = pos_ff;
      chk_in     = chk_ff;
      matched_in = matched_ff;
      evt        = '0;
      evt.status = ST_GOOD;
      if (acc) begin
         if (pos_ff == '0) begin
            if (rx_byte == start_marker_ff) begin
               pos_in     = PW'(1);
               chk_in     = check_seed_ff;
               matched_in = 1'b0;
            end
         end else if (!at_end) begin
            if (rx_byte == start_marker_ff) begin
               // restart the frame at this byte
               pos_in     = PW'(1);
               chk_in     = check_seed_ff;
               matched_in = 1'b0;
            end else begin
               if (pos_ff < PW'(CHECK_POS)) begin
                  evt.wr_en = 1'b1;
                  chk_in    = chk_ff ^ rx_byte;
               end else begin
                  matched_in = (rx_byte == chk_ff);
               end
               pos_in = pos_ff + 1'b1;
            end
         end else begin
            pos_in = '0;
            if (rx_byte != end_marker_ff) begin
               evt.bad    = 1'b1;
               evt.status = ST_BAD_END;
            end else if (!matched_ff) begin
               evt.bad    = 1'b1;
               evt.status = ST_BAD_CHECK;
            end else begin
               evt.good   = 1'b1;
               matched_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         chk_ff     <= CHECK_SEED_RST;
         matched_ff <= 1'b0;
      end else begin
         pos_ff     <= pos_in;
         chk_ff     <= chk_in;
         matched_ff <= matched_in;
      end
   end

   ffdx_body_buf #(
      .BODY_LEN (BODY_LEN),
      .IDXW     (IDXW)
   ) u_body_buf (
      .clock      (clock),
      .reset      (reset),
      .evt        (evt),
      .wr_idx     (IDXW'(body_off)),
      .wr_data    (rx_byte),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_word   (rsp_word)
   );

   assign rsp_tdata = {4'd0, rsp_word.body_index, rsp_word.body_byte};
   assign rsp_tuser = rsp_word.status;
   assign rsp_tlast = rsp_word.last;

   `FFDX_ASSERT_NEVER(a_pos_range, pos_ff > PW'(END_POS), "frame position out of range")
   `FFDX_ASSERT_IMPLY(a_final_gated, acc && at_end, !stat.drain_busy && stat.slot_free,
      "final byte taken without output space")
   `FFDX_ASSERT_NEXT(a_verdict_resets, acc && at_end, pos_ff == '0,
      "frame not closed after final byte")

endmodule
